// File: src/bsm_pkg.sv
// Package for the bounded stack with minimum query.
// Holds sizes, command and status codes, and the request, response and cell types.
// No dependencies; every other file in src uses it by scoped names.
package bsm_pkg;

  // Number of cells in the stack chain
  localparam int unsigned DEPTH = 256;
  // Width that can hold any fill level from 0 to DEPTH
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // Width of the capacity register, as the register map fixes it
  localparam int unsigned CAP_W = 9;
  // Width used when the capacity is compared with the fill level
  localparam int unsigned CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int unsigned WORD_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  // Command codes. Codes 5 to 7 are unused.
  typedef enum logic [2:0] {
    CMD_PUSH       = 3'd0,
    CMD_PUSH_BELOW = 3'd1,
    CMD_PUSH_ABOVE = 3'd2,
    CMD_POP        = 3'd3,
    CMD_MIN        = 3'd4
  } cmd_e_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    status_t                  status;
    logic [CNT_W-1:0]         fill_level;
  } rsp_t;

  // One stack entry: the word and the minimum of it and all entries beneath it
  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic signed [WORD_W-1:0] minv;
  } entry_t;

  // Shift control broadcast along the chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

// File: src/bounded_stack_with_min_query.sv
// Top level of the bounded stack with minimum query: command decode, fill count,
// capacity register, response register and the chain of bsm_cell stages.
// Depends on bsm_pkg and bsm_cell.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   req     | in        | req_valid / req_stall | command, value (bsm_pkg::req_t)
//   rsp     | out       | rsp_valid / rsp_stall | result_value, status, fill_level
//   cfg     | in        | cfg_valid / cfg_ready | capacity (9 bits)
//
// A command is decoded and the whole chain shifts in the cycle it is accepted; its
// response sits in the output register from the next cycle, one command per cycle
// while the response side keeps taking. The top cell carries the minimum of the
// whole stack, so a minimum query costs no more than a pop.
// A request is held off only while a response waits under stall.
// Reset empties the stack at once and sets capacity to 256; cell contents are not
// cleared, as only held entries are ever read.
module bounded_stack_with_min_query (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  bsm_pkg::req_t                     req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output bsm_pkg::rsp_t                     rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bsm_pkg::CAP_W-1:0]         cfg_data
);

  logic [bsm_pkg::CNT_W-1:0] count;
  logic [bsm_pkg::CNT_W-1:0] count_next;
  logic [bsm_pkg::CAP_W-1:0] capacity;
  logic                      rsp_valid_next;
  bsm_pkg::rsp_t             rsp_next;

  bsm_pkg::shift_ctl_t ctl;
  bsm_pkg::entry_t     new_entry;
  bsm_pkg::entry_t     cells [bsm_pkg::DEPTH];
  bsm_pkg::entry_t     top;

  logic                      accept;
  logic                      nonempty;
  logic                      full;
  logic                      order_bad;
  logic [bsm_pkg::CMP_W-1:0] eff_cap;

  assign cfg_ready = 1'b1;
  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  assign top      = cells[0];
  assign nonempty = (count != '0);

  // Effective capacity is the register clipped to the chain length
  always_comb begin
    if (bsm_pkg::CMP_W'(capacity) > bsm_pkg::CMP_W'(bsm_pkg::DEPTH)) begin
      eff_cap = bsm_pkg::CMP_W'(bsm_pkg::DEPTH);
    end else begin
      eff_cap = bsm_pkg::CMP_W'(capacity);
    end
  end
  assign full = (bsm_pkg::CMP_W'(count) >= eff_cap);

  // Order check against the top entry, only meaningful when not empty
  always_comb begin
    if (req.command == bsm_pkg::CMD_PUSH_BELOW) begin
      order_bad = !(req.value < top.data);
    end else begin
      order_bad = !(top.data < req.value);
    end
  end

  // New top entry carries the minimum of the pushed word and the old stack
  always_comb begin
    new_entry.data = req.value;
    if (nonempty && (top.minv < req.value)) begin
      new_entry.minv = top.minv;
    end else begin
      new_entry.minv = req.value;
    end
  end

  // Command decode
  always_comb begin
    ctl                   = '0;
    count_next            = count;
    rsp_next.result_value = '0;
    rsp_next.status       = bsm_pkg::ST_OK;
    case (req.command)
      bsm_pkg::CMD_PUSH: begin
        if (full) begin
          rsp_next.status = bsm_pkg::ST_FULL;
        end else begin
          ctl.push = 1'b1;
        end
      end
      bsm_pkg::CMD_PUSH_BELOW, bsm_pkg::CMD_PUSH_ABOVE: begin
        if (nonempty && order_bad) begin
          rsp_next.status = bsm_pkg::ST_ORDER;
        end else if (full) begin
          rsp_next.status = bsm_pkg::ST_FULL;
        end else begin
          ctl.push = 1'b1;
        end
      end
      bsm_pkg::CMD_POP: begin
        if (!nonempty) begin
          rsp_next.status = bsm_pkg::ST_EMPTY;
        end else begin
          ctl.pop               = 1'b1;
          rsp_next.result_value = top.data;
        end
      end
      bsm_pkg::CMD_MIN: begin
        if (!nonempty) begin
          rsp_next.status = bsm_pkg::ST_EMPTY;
        end else begin
          rsp_next.result_value = top.minv;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctl = '0;
    end
    if (ctl.push) begin
      count_next = count + 1'b1;
    end else if (ctl.pop) begin
      count_next = count - 1'b1;
    end
    rsp_next.fill_level = count_next;
  end

  // Response register valid flag
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (accept) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      capacity  <= bsm_pkg::CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Chain of cells, top at index 0
  for (genvar i = 0; i < bsm_pkg::DEPTH; i++) begin : g_cell
    bsm_pkg::entry_t upper;
    bsm_pkg::entry_t lower;
    if (i == 0) begin : g_top
      assign upper = new_entry;
    end else begin : g_mid
      assign upper = cells[i-1];
    end
    if (i == bsm_pkg::DEPTH - 1) begin : g_bot
      assign lower = cells[i];
    end else begin : g_low
      assign lower = cells[i+1];
    end
    bsm_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .upper (upper),
      .lower (lower),
      .q     (cells[i])
    );
  end

  // Fill count never exceeds the chain length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= bsm_pkg::CNT_W'(bsm_pkg::DEPTH))
    else $error("fill count beyond chain length");

  // A waiting response reports the current fill level
  a_fill_matches: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.fill_level == count)
    else $error("response fill level out of step with count");

  // Running minimum at the top never exceeds the top word
  a_min_le_top: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> !(top.data < top.minv))
    else $error("running minimum above top entry");

  // Empty status only on an empty stack
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == bsm_pkg::ST_EMPTY) |-> rsp.fill_level == '0)
    else $error("empty status with entries held");

  // A successful push grows the stack by one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> count == $past(count) + 1'b1)
    else $error("push did not grow the stack");

endmodule

// File: src/bsm_cell.sv
// One cell of the stack chain: holds one entry and its running minimum.
// Takes from the cell above on a push and from the cell below on a pop.
// Depends on bsm_pkg.
module bsm_cell (
  input  logic                clk,
  input  bsm_pkg::shift_ctl_t ctl,
  input  bsm_pkg::entry_t     upper,
  input  bsm_pkg::entry_t     lower,
  output bsm_pkg::entry_t     q
);

  bsm_pkg::entry_t entry;
  bsm_pkg::entry_t entry_next;

  // Shift towards the bottom on push, towards the top on pop, else hold
  always_comb begin
    entry_next = entry;
    if (ctl.push) begin
      entry_next = upper;
    end else if (ctl.pop) begin
      entry_next = lower;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign q = entry;

endmodule

// File: bench/bsm_stack_checker.sv
// Checker for the bounded stack with minimum query: watches the request, response and
// capacity channels, keeps a shadow stack and compares every response with it.
// Depends on bsm_pkg for the request, response, command and status types.
module bsm_stack_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  bsm_pkg::req_t         req,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  bsm_pkg::rsp_t         rsp,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [bsm_pkg::CAP_W-1:0] cfg_data,
  output int                    fails,
  output int                    pending,
  output int                    requests,
  output int                    responses,
  output int                    full_hits,
  output int                    order_hits,
  output int                    empty_hits,
  output int                    peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;
  import bsm_pkg::*;

  // Shadow of the stack contents, fill count and capacity register
  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  int unsigned              shadow_count;
  logic [CAP_W-1:0]         shadow_cap;

  // Responses owed by the block, oldest first
  rsp_t owed_responses [$];
  rsp_t want;
  int   err_total;
  int   req_total;
  int   rsp_total;
  int   status_hits [4];
  int   fill_max;

  // One line per mismatch; printing stops after a while, counting does not
  task automatic report_mismatch(input string what, input logic [31:0] exp_word,
                                 input logic [31:0] got_word);
    if (err_total < 50) begin
      $display("MISMATCH at response %0d, %s: expected %h, got %h",
               rsp_total, what, exp_word, got_word);
    end
    err_total++;
  endtask

  // Apply one request to the shadow stack and work out the response it owes
  function automatic rsp_t next_stack_response(input req_t r);
    rsp_t                     res;
    logic signed [WORD_W-1:0] word;
    logic signed [WORD_W-1:0] top_word;
    int unsigned              lim;
    int unsigned              i;
    res = '0;
    res.status = ST_OK;
    word = r.value;
    lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    case (r.command)
      CMD_PUSH, CMD_PUSH_BELOW, CMD_PUSH_ABOVE: begin
        // order check first (skipped on an empty stack), then capacity
        if (shadow_count > 0) begin
          top_word = shadow_words[shadow_count - 1];
          if (r.command == CMD_PUSH_BELOW && !(word < top_word)) res.status = ST_ORDER;
          if (r.command == CMD_PUSH_ABOVE && !(top_word < word)) res.status = ST_ORDER;
        end
        if (res.status == ST_OK) begin
          if (shadow_count >= lim) begin
            res.status = ST_FULL;
          end else begin
            shadow_words[shadow_count] = word;
            shadow_count++;
          end
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_count--;
          res.result_value = shadow_words[shadow_count];
        end
      end
      CMD_MIN: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.result_value = shadow_words[0];
          for (i = 1; i < shadow_count; i++) begin
            if (shadow_words[i] < res.result_value) res.result_value = shadow_words[i];
          end
        end
      end
      default: ;  // spare codes change nothing
    endcase
    res.fill_level = CNT_W'(shadow_count);
    return res;
  endfunction

  // Watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      shadow_cap = CAP_RESET;
      owed_responses.delete();
    end else begin
      if (cfg_valid && cfg_ready) shadow_cap = cfg_data;
      // responses first: they always belong to earlier requests
      if (rsp_valid && !rsp_stall) begin
        rsp_total++;
        if (owed_responses.size() == 0) begin
          report_mismatch("response with none owed, result_value", '0, rsp.result_value);
        end else begin
          want = owed_responses.pop_front();
          status_hits[want.status]++;
          if (rsp.result_value !== want.result_value)
            report_mismatch("result_value", want.result_value, rsp.result_value);
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(rsp.status));
          if (rsp.fill_level !== want.fill_level)
            report_mismatch("fill_level", 32'(want.fill_level), 32'(rsp.fill_level));
        end
      end
      if (req_valid && !req_stall) begin
        req_total++;
        owed_responses.push_back(next_stack_response(req));
        if (shadow_count > fill_max) fill_max = shadow_count;
      end
    end
    fails      <= err_total;
    pending    <= owed_responses.size();
    requests   <= req_total;
    responses  <= rsp_total;
    full_hits  <= status_hits[ST_FULL];
    order_hits <= status_hits[ST_ORDER];
    empty_hits <= status_hits[ST_EMPTY];
    peak_fill  <= fill_max;
  end

endmodule

// File: bench/bounded_stack_with_min_query_test.sv
// Top of the bench for the bounded stack with minimum query: clock, reset, request and
// capacity stimulus, random response stall, watchdog and verdict.
// Depends on bsm_pkg, bounded_stack_with_min_query and bsm_stack_checker.
module bounded_stack_with_min_query_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bsm_pkg::*;

  localparam int            WATCHDOG_LIMIT   = 4000;
  localparam logic [2:0]    FIRST_UNUSED_CMD = 3'(CMD_MIN) + 3'd1;
  localparam logic [WORD_W-1:0] WORD_MAX     = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MIN     = 32'h8000_0000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req_bus = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp_bus;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  int fails, pending, requests, responses;
  int full_hits, order_hits, empty_hits, peak_fill;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_stack_with_min_query DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_bus),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_bus),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bsm_stack_checker stack_watch (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req_bus),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp_bus),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fails      (fails),
    .pending    (pending),
    .requests   (requests),
    .responses  (responses),
    .full_hits  (full_hits),
    .order_hits (order_hits),
    .empty_hits (empty_hits),
    .peak_fill  (peak_fill)
  );

  // Response side stalls at random
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: ends the run after too long with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d responses still owed",
               quiet_cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Send one request, with random idle cycles ahead of it
  task automatic issue(input logic [2:0] cmd, input logic [WORD_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_bus   <= '{command: cmd, value: val};
    do @(posedge clk); while (req_stall);
  endtask

  // Write capacity once every owed response has come back
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mix of full-range words, small values near zero (so ordered pushes go both
  // ways) and the two extremes
  function automatic logic [WORD_W-1:0] random_word();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return $urandom;
    if (pick < 8) return WORD_W'(int'($urandom_range(16)) - 8);
    if (pick == 8) return WORD_MAX;
    return WORD_MIN;
  endfunction

  // Random commands: push weight, pop weight, the rest mostly minimum queries
  task automatic random_phase(input int n, input int w_push, input int w_pop);
    int         k;
    int         pick;
    logic [2:0] cmd;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < w_push) begin
        if ($urandom_range(1)) cmd = CMD_PUSH;
        else cmd = $urandom_range(1) ? CMD_PUSH_BELOW : CMD_PUSH_ABOVE;
      end else if (pick < w_push + w_pop) begin
        cmd = CMD_POP;
      end else if (pick % 5 == 0) begin
        cmd = FIRST_UNUSED_CMD + 3'($urandom_range(2));
      end else begin
        cmd = CMD_MIN;
      end
      issue(cmd, random_word());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty stack, ordered pushes at the word extremes and on equal
    // values, spare codes, draining to empty; capacity at its reset value
    issue(CMD_MIN, '0);
    issue(CMD_POP, '0);
    issue(CMD_PUSH_ABOVE, WORD_MIN);     // empty stack skips the order check
    issue(CMD_PUSH_BELOW, WORD_MIN);     // equal to top
    issue(CMD_PUSH_ABOVE, WORD_MIN);     // equal to top
    issue(CMD_PUSH_ABOVE, WORD_MAX);
    issue(CMD_PUSH_ABOVE, WORD_MAX);
    issue(CMD_PUSH_BELOW, WORD_MIN);
    issue(CMD_PUSH_BELOW, WORD_MAX);
    issue(CMD_PUSH, '1);
    issue(CMD_PUSH, '0);
    issue(CMD_MIN, WORD_MAX);
    issue(FIRST_UNUSED_CMD, WORD_MAX);
    issue(FIRST_UNUSED_CMD + 3'd1, WORD_MIN);
    issue(FIRST_UNUSED_CMD + 3'd2, '1);
    repeat (5) issue(CMD_POP, '1);
    issue(CMD_MIN, '0);
    issue(CMD_PUSH_BELOW, '0);
    issue(CMD_POP, '0);

    // Capacity above the stack depth, filling fast
    set_capacity(9'd511);
    random_phase(180, 80, 12);

    // Capacity well below the fill, sender idling
    set_capacity(9'd1);
    idle_pct = 62;
    random_phase(50, 40, 30);

    // Capacity zero, receiver stalling
    idle_pct = 0;
    stall_pct = 62;
    set_capacity(9'd0);
    random_phase(40, 60, 20);

    // Full capacity, pushed until refused
    set_capacity(9'd256);
    random_phase(330, 90, 5);

    // Drain towards empty, both sides idling now and then
    idle_pct = 16;
    stall_pct = 16;
    random_phase(280, 5, 85);

    // Small capacity, sender idling
    idle_pct = 62;
    stall_pct = 0;
    set_capacity(9'd9);
    random_phase(100, 50, 35);

    // Wait for every owed response, then a few cycles for strays
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("Ran %0d requests and checked %0d responses over capacities 256, 511, 1, 0, 9;",
             requests, responses);
    $display("peak fill %0d, refusals: %0d full, %0d order, %0d empty.",
             peak_fill, full_hits, order_hits, empty_hits);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fails);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
